// ===== rtl/core/srt_pkg.sv =====
// shared types, constants and helpers for the score ranked table
package srt_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int SCORE_W      = 7;
   localparam int TAG_W        = 16;
   localparam int TOTAL_W      = 9;
   localparam int AVG_W        = 7;
   localparam int RANK_IDX_W   = 6;
   localparam int RANK_W       = 7;
   localparam int COUNT_OUT_W  = 7;
   localparam int SCORE_MAX    = 100;

   // floor(t / 3) for t below 512 as a multiply by 171 and shift by 9
   localparam int DIV3_MUL     = 171;
   localparam int DIV3_SHIFT   = 9;
   localparam int DIV3_PROD_W  = 17;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_READ   = 1'b1
   } cmd_code_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_BAD   = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RDWAIT,
      ST_SHIFT,
      ST_PLACE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_CNT_M1,
      RD_PTR_M2
   } rdsel_type;

   typedef enum logic {
      WR_NEW,
      WR_SHIFT
   } wrsel_type;

   typedef enum logic [2:0] {
      RES_INSERT_OK,
      RES_FULL,
      RES_BAD,
      RES_EMPTY,
      RES_READ
   } ressel_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score_first;
      logic [SCORE_W-1:0] score_second;
      logic [SCORE_W-1:0] score_third;
      logic [TAG_W-1:0]   tag;
      logic [TOTAL_W-1:0] total;
   } rec_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      rdsel_type  rd_sel;
      logic       wr_en;
      wrsel_type  wr_sel;
      logic       ptr_load;
      logic       ptr_dec;
      logic       count_inc;
      logic       res_load;
      ressel_type res_sel;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_read;
      logic bad_score;
      logic full;
      logic idx_ok;
      logic count_zero;
      logic shift_more;
      logic ptr_is_one;
      logic out_free;
   } dp_stat_type;

   function automatic logic [AVG_W-1:0] div3(input logic [TOTAL_W-1:0] t);
      logic [DIV3_PROD_W-1:0] p;
      p = DIV3_PROD_W'(t) * DIV3_PROD_W'(DIV3_MUL);
      return AVG_W'(p >> DIV3_SHIFT);
   endfunction

endpackage

// ===== rtl/core/srt_ram.sv =====
// generic single write port ram with registered read
module srt_ram #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srt_ctrl.sv =====
// sequencer for insert walk, reads and result hand-off
module srt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  srt_pkg::dp_stat_type stat,
   output srt_pkg::ctrl_cmd_type cmd
);

   srt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_sel   = srt_pkg::RD_IDX;
      cmd.wr_sel   = srt_pkg::WR_NEW;
      cmd.res_sel  = srt_pkg::RES_EMPTY;
      req_ready    = 1'b0;
      unique case (state_ff)
         srt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = srt_pkg::ST_DECIDE;
            end
         end
         srt_pkg::ST_DECIDE: begin
            priority if (stat.is_read && !stat.idx_ok) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = srt_pkg::RES_EMPTY;
               state_in     = srt_pkg::ST_FINISH;
            end else if (stat.is_read) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = srt_pkg::RD_IDX;
               state_in   = srt_pkg::ST_RDWAIT;
            end else if (stat.bad_score) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = srt_pkg::RES_BAD;
               state_in     = srt_pkg::ST_FINISH;
            end else if (stat.full) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = srt_pkg::RES_FULL;
               state_in     = srt_pkg::ST_FINISH;
            end else if (stat.count_zero) begin
               cmd.ptr_load = 1'b1;
               state_in     = srt_pkg::ST_PLACE;
            end else begin
               cmd.ptr_load = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_sel   = srt_pkg::RD_CNT_M1;
               state_in     = srt_pkg::ST_SHIFT;
            end
         end
         srt_pkg::ST_RDWAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = srt_pkg::RES_READ;
            state_in     = srt_pkg::ST_FINISH;
         end
         srt_pkg::ST_SHIFT: begin
            cmd.wr_en = 1'b1;
            if (stat.shift_more) begin
               // move the record one place down and look at the next one up
               cmd.wr_sel  = srt_pkg::WR_SHIFT;
               cmd.ptr_dec = 1'b1;
               if (stat.ptr_is_one) begin
                  state_in = srt_pkg::ST_PLACE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = srt_pkg::RD_PTR_M2;
               end
            end else begin
               cmd.wr_sel    = srt_pkg::WR_NEW;
               cmd.count_inc = 1'b1;
               cmd.res_load  = 1'b1;
               cmd.res_sel   = srt_pkg::RES_INSERT_OK;
               state_in      = srt_pkg::ST_FINISH;
            end
         end
         srt_pkg::ST_PLACE: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = srt_pkg::WR_NEW;
            cmd.count_inc = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_sel   = srt_pkg::RES_INSERT_OK;
            state_in      = srt_pkg::ST_FINISH;
         end
         srt_pkg::ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = srt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srt_pkg::ST_IDLE;
         end
      endcase
   end

   // memory data is only consumed the cycle after a read was issued
   a_shift_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srt_pkg::ST_SHIFT) |-> $past(cmd.rd_en))
      else $error("shift step without a preceding memory read");

   a_rdwait_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srt_pkg::ST_RDWAIT) |-> $past(cmd.rd_en))
      else $error("read result stage without a preceding memory read");

endmodule

// ===== rtl/core/srt_dp.sv =====
// record registers, table memory, counters and output register
module srt_dp #(
   parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_cmd,
   input  logic [srt_pkg::SCORE_W-1:0]        req_score_first,
   input  logic [srt_pkg::SCORE_W-1:0]        req_score_second,
   input  logic [srt_pkg::SCORE_W-1:0]        req_score_third,
   input  logic [srt_pkg::TAG_W-1:0]          req_record_tag,
   input  logic [srt_pkg::RANK_IDX_W-1:0]     req_rank_index,
   input  srt_pkg::ctrl_cmd_type              cmd,
   output srt_pkg::dp_stat_type               stat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [srt_pkg::TOTAL_W-1:0]        rsp_total_score,
   output logic [srt_pkg::AVG_W-1:0]          rsp_average_score,
   output logic [srt_pkg::SCORE_W-1:0]        rsp_out_first,
   output logic [srt_pkg::SCORE_W-1:0]        rsp_out_second,
   output logic [srt_pkg::SCORE_W-1:0]        rsp_out_third,
   output logic [srt_pkg::TAG_W-1:0]          rsp_out_tag,
   output logic [srt_pkg::RANK_W-1:0]         rsp_rank_number,
   output logic [srt_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int AW     = $clog2(CAPACITY);
   localparam int CmpW   = (CW > srt_pkg::RANK_IDX_W) ? CW : srt_pkg::RANK_IDX_W;
   localparam int RankW  = srt_pkg::RANK_W;
   localparam int CountW = srt_pkg::COUNT_OUT_W;
   localparam int TotW   = srt_pkg::TOTAL_W;
   localparam int ScW    = srt_pkg::SCORE_W;
   localparam int RecW   = $bits(srt_pkg::rec_type);

   srt_pkg::rec_type               nrec_ff, res_rec_ff, out_rec_ff, rd_rec, res_rec_in;
   logic                           is_read_ff;
   logic [srt_pkg::RANK_IDX_W-1:0] idx_ff;
   logic [CW-1:0]                  ptr_ff, count_ff;
   srt_pkg::status_type            res_status_ff, res_status_in, out_status_ff;
   logic [RankW-1:0]               res_rank_ff, res_rank_in, out_rank_ff;
   logic [srt_pkg::AVG_W-1:0]      out_avg_ff;
   logic [CountW-1:0]              out_count_ff;
   logic                           rsp_valid_ff;
   logic [AW-1:0]                  rd_addr, wr_addr;
   logic [RecW-1:0]                wr_data, rd_data;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         nrec_ff.score_first  <= req_score_first;
         nrec_ff.score_second <= req_score_second;
         nrec_ff.score_third  <= req_score_third;
         nrec_ff.tag          <= req_record_tag;
         nrec_ff.total        <= TotW'(req_score_first) + TotW'(req_score_second)
                                 + TotW'(req_score_third);
         is_read_ff           <= (req_cmd == srt_pkg::CMD_READ);
         idx_ff               <= req_rank_index;
      end
      if (cmd.ptr_load) begin
         ptr_ff <= count_ff;
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_ff - CW'(1);
      end
      if (cmd.res_load) begin
         res_status_ff <= res_status_in;
         res_rank_ff   <= res_rank_in;
         res_rec_ff    <= res_rec_in;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_rank_ff   <= res_rank_ff;
         out_rec_ff    <= res_rec_ff;
         out_avg_ff    <= srt_pkg::div3(res_rec_ff.total);
         out_count_ff  <= CountW'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.count_inc) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // memory addressing
   always_comb begin
      unique case (cmd.rd_sel)
         srt_pkg::RD_IDX:    rd_addr = AW'(idx_ff);
         srt_pkg::RD_CNT_M1: rd_addr = AW'(count_ff - CW'(1));
         srt_pkg::RD_PTR_M2: rd_addr = AW'(ptr_ff - CW'(2));
         default:            rd_addr = '0;
      endcase
      wr_addr = AW'(ptr_ff);
      unique case (cmd.wr_sel)
         srt_pkg::WR_SHIFT: wr_data = rd_data;
         default:           wr_data = nrec_ff;
      endcase
   end

   assign rd_rec = rd_data;

   srt_ram #(
      .WIDTH(RecW),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // result selection
   always_comb begin
      res_rec_in    = '0;
      res_rank_in   = '0;
      res_status_in = srt_pkg::STATUS_OK;
      unique case (cmd.res_sel)
         srt_pkg::RES_INSERT_OK: begin
            res_rec_in  = nrec_ff;
            res_rank_in = RankW'(ptr_ff) + RankW'(1);
         end
         srt_pkg::RES_FULL: begin
            res_status_in = srt_pkg::STATUS_FULL;
            res_rec_in    = nrec_ff;
         end
         srt_pkg::RES_BAD: begin
            res_status_in  = srt_pkg::STATUS_BAD;
            res_rec_in.tag = nrec_ff.tag;
         end
         srt_pkg::RES_READ: begin
            res_rec_in  = rd_rec;
            res_rank_in = RankW'(idx_ff) + RankW'(1);
         end
         default: begin
            res_status_in = srt_pkg::STATUS_EMPTY;
         end
      endcase
   end

   always_comb begin
      stat.is_read    = is_read_ff;
      stat.bad_score  = (nrec_ff.score_first > ScW'(srt_pkg::SCORE_MAX))
                        || (nrec_ff.score_second > ScW'(srt_pkg::SCORE_MAX))
                        || (nrec_ff.score_third > ScW'(srt_pkg::SCORE_MAX));
      stat.full       = (count_ff == CW'(CAPACITY));
      stat.idx_ok     = (CmpW'(idx_ff) < CmpW'(count_ff));
      stat.count_zero = (count_ff == '0);
      // ties move down so the newest of equal totals lands first
      stat.shift_more = (rd_rec.total <= nrec_ff.total);
      stat.ptr_is_one = (ptr_ff == CW'(1));
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_total_score   = out_rec_ff.total;
   assign rsp_average_score = out_avg_ff;
   assign rsp_out_first     = out_rec_ff.score_first;
   assign rsp_out_second    = out_rec_ff.score_second;
   assign rsp_out_third     = out_rec_ff.score_third;
   assign rsp_out_tag       = out_rec_ff.tag;
   assign rsp_rank_number   = out_rank_ff;
   assign rsp_entry_count   = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("record count beyond capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (ptr_ff < CW'(CAPACITY)))
      else $error("table write outside the memory");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("record count changed by other than one");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

endmodule

// ===== rtl/core/score_ranked_table.sv =====
// top level of the score ranked table
// Holds up to CAPACITY records sorted by descending total of three scores; equal totals
// put the newest record first. Each item returns exactly one result. An insert walks
// the table from its end, moving one stored record per cycle through the record
// memory until it reaches the new record's place, then writes it there. A read waits
// for the registered memory read; a rejected insert or a read of an empty rank goes
// straight from the decision to the result.
// Items are taken one at a time; the result sits in an output register so the next
// item can be accepted while it waits. The memory needs no clearing after reset.
module score_ranked_table #(
   parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [srt_pkg::SCORE_W-1:0]     req_score_first,
   input  logic [srt_pkg::SCORE_W-1:0]     req_score_second,
   input  logic [srt_pkg::SCORE_W-1:0]     req_score_third,
   input  logic [srt_pkg::TAG_W-1:0]       req_record_tag,
   input  logic [srt_pkg::RANK_IDX_W-1:0]  req_rank_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [srt_pkg::TOTAL_W-1:0]     rsp_total_score,
   output logic [srt_pkg::AVG_W-1:0]       rsp_average_score,
   output logic [srt_pkg::SCORE_W-1:0]     rsp_out_first,
   output logic [srt_pkg::SCORE_W-1:0]     rsp_out_second,
   output logic [srt_pkg::SCORE_W-1:0]     rsp_out_third,
   output logic [srt_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [srt_pkg::RANK_W-1:0]      rsp_rank_number,
   output logic [srt_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);

   srt_pkg::ctrl_cmd_type cmd;
   srt_pkg::dp_stat_type  stat;

   srt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   srt_dp #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_score_first  (req_score_first),
      .req_score_second (req_score_second),
      .req_score_third  (req_score_third),
      .req_record_tag   (req_record_tag),
      .req_rank_index   (req_rank_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_total_score  (rsp_total_score),
      .rsp_average_score(rsp_average_score),
      .rsp_out_first    (rsp_out_first),
      .rsp_out_second   (rsp_out_second),
      .rsp_out_third    (rsp_out_third),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_rank_number  (rsp_rank_number),
      .rsp_entry_count  (rsp_entry_count)
   );

endmodule
